// ----- rtl/xs_pkg.sv -----
// Shared types and constants for the xoshiro256** generator.
package xs_pkg;

  localparam int WORD_W  = 64;
  localparam int SEED_W  = 31;
  localparam int RANGE_W = 32;
  localparam int FRAC_W  = 52;
  localparam int HALF_W  = 26;
  localparam int PROD_W  = HALF_W + RANGE_W;
  localparam int JUMP_W  = 256;
  localparam int CNT_W   = $clog2(JUMP_W);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_DRAW   = 2'd0,
    ACT_JUMP   = 2'd1,
    ACT_RESEED = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Jump polynomial, word 0 in the low bits; bit i is used on jump step i.
  localparam logic [JUMP_W-1:0] JUMP_POLY = {
    64'h39abdc4529b1661c,
    64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c,
    64'h180ec6d33cfd0aba
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic seed_write;
    logic load_draw;
    logic load_jump;
    logic load_seed;
    logic raw_mul;
    logic prod;
    logic sum;
    logic jump_step;
    logic jump_bit;
    logic jump_copy;
    logic emit;
    logic emit_draw;
  } xs_cmd_t;

endpackage

// ----- rtl/xoshiro256ss_generator.sv -----
// Top level of the xoshiro256** generator: controller plus datapath.
//
//  channel   signals                              direction  handshake
//  input     in_valid, in_stall, action,          in         valid / stall
//            range_max
//  output    out_valid, out_stall, raw_value,     out        valid / stall
//            fraction, ranged_value
//  config    cfg_valid, cfg_ready, seed           in         valid / ready
//
// One transaction at a time. A draw passes scramble, times nine, two 26x32 multiplies
// and a sum before the result register; a jump runs 256 sequential state steps, then
// copies the accumulator into the state; reseed and the unused code go straight to emit.
// Reset is synchronous: state words 1, 2, 3, 4 and seed 1.
// A stalled result stays in the output register; the next transaction is taken
// meanwhile and waits in its last stage until the register frees.
module xoshiro256ss_generator import xs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          action,
  input  logic [RANGE_W-1:0]  range_max,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WORD_W-1:0]   raw_value,
  output logic [FRAC_W-1:0]   fraction,
  output logic [RANGE_W-1:0]  ranged_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SEED_W-1:0]   seed
);

  xs_cmd_t cmd;

  xs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  xs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .seed         (seed),
    .range_max    (range_max),
    .raw_value    (raw_value),
    .fraction     (fraction),
    .ranged_value (ranged_value)
  );

endmodule

// ----- rtl/xs_datapath.sv -----
// Datapath: generator state, jump accumulator, output scrambler and range scaling.
module xs_datapath import xs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  xs_cmd_t             cmd,
  input  logic [SEED_W-1:0]   seed,
  input  logic [RANGE_W-1:0]  range_max,
  output logic [WORD_W-1:0]   raw_value,
  output logic [FRAC_W-1:0]   fraction,
  output logic [RANGE_W-1:0]  ranged_value
);

  typedef word_t gen_state_t [4];

  gen_state_t          gen_state;
  gen_state_t          gen_state_next;
  gen_state_t          acc;
  logic [SEED_W-1:0]   seed_reg;
  logic [RANGE_W-1:0]  range_q;
  word_t               rot5;
  word_t               raw;
  logic [PROD_W-1:0]   lo_prod;
  logic [PROD_W-1:0]   hi_prod;
  logic [PROD_W-1:0]   mid;
  logic [RANGE_W-1:0]  sum_q;
  word_t               s1_x5;
  word_t               seed_ext;

  // One xoshiro256 state transition.
  always_comb begin
    word_t t;
    t = gen_state[1] << 17;
    gen_state_next[2] = gen_state[2] ^ gen_state[0];
    gen_state_next[3] = gen_state[3] ^ gen_state[1];
    gen_state_next[1] = gen_state[1] ^ gen_state_next[2];
    gen_state_next[0] = gen_state[0] ^ gen_state_next[3];
    gen_state_next[2] = gen_state_next[2] ^ t;
    gen_state_next[3] = {gen_state_next[3][18:0], gen_state_next[3][63:19]};
  end

  assign s1_x5    = gen_state[1] + (gen_state[1] << 2);
  assign seed_ext = WORD_W'(seed_reg);
  assign mid      = hi_prod + PROD_W'(lo_prod[PROD_W-1:HALF_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state[0] <= WORD_W'(1);
      gen_state[1] <= WORD_W'(2);
      gen_state[2] <= WORD_W'(3);
      gen_state[3] <= WORD_W'(4);
      seed_reg     <= SEED_W'(1);
    end else begin
      if (cmd.seed_write) begin
        seed_reg <= seed;
      end
      if (cmd.load_draw || cmd.jump_step) begin
        gen_state <= gen_state_next;
      end else if (cmd.load_seed) begin
        gen_state[0] <= seed_ext;
        gen_state[1] <= seed_ext + WORD_W'(1);
        gen_state[2] <= seed_ext + WORD_W'(2);
        gen_state[3] <= seed_ext + WORD_W'(3);
      end else if (cmd.jump_copy) begin
        gen_state <= acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_jump) begin
      for (int k = 0; k < 4; k++) begin
        acc[k] <= '0;
      end
    end else if (cmd.jump_step && cmd.jump_bit) begin
      for (int k = 0; k < 4; k++) begin
        acc[k] <= acc[k] ^ gen_state[k];
      end
    end
  end

  // Draw pipeline: rotate, times nine, split multiply, sum.
  always_ff @(posedge clk) begin
    if (cmd.load_draw) begin
      rot5    <= {s1_x5[56:0], s1_x5[63:57]};
      range_q <= range_max;
    end
    if (cmd.raw_mul) begin
      raw <= rot5 + (rot5 << 3);
    end
    if (cmd.prod) begin
      lo_prod <= PROD_W'(raw[12 +: HALF_W]) * PROD_W'(range_q);
      hi_prod <= PROD_W'(raw[12 + HALF_W +: HALF_W]) * PROD_W'(range_q);
    end
    if (cmd.sum) begin
      sum_q <= mid[PROD_W-1:HALF_W];
    end
    if (cmd.emit) begin
      if (cmd.emit_draw) begin
        raw_value    <= raw;
        fraction     <= raw[WORD_W-1:WORD_W-FRAC_W];
        ranged_value <= sum_q + RANGE_W'(1);
      end else begin
        raw_value    <= '0;
        fraction     <= '0;
        ranged_value <= '0;
      end
    end
  end

endmodule

// ----- rtl/xs_ctrl.sv -----
// Controller: sequences draw, jump and reseed transactions and owns the handshakes.
module xs_ctrl import xs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  output xs_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAW,
    S_MUL,
    S_SUM,
    S_JUMP,
    S_JCOPY,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             is_draw;
  logic             accept;
  logic             out_free;
  action_t          act;

  assign act       = action_t'(action);
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = in_valid && (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.seed_write = cfg_valid && cfg_ready;
    cmd.load_draw  = accept && (act == ACT_DRAW);
    cmd.load_jump  = accept && (act == ACT_JUMP);
    cmd.load_seed  = accept && (act == ACT_RESEED);
    cmd.raw_mul    = (state == S_RAW);
    cmd.prod       = (state == S_MUL);
    cmd.sum        = (state == S_SUM);
    cmd.jump_step  = (state == S_JUMP);
    cmd.jump_bit   = JUMP_POLY[cnt];
    cmd.jump_copy  = (state == S_JCOPY);
    cmd.emit       = (state == S_EMIT) && out_free;
    cmd.emit_draw  = is_draw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      is_draw   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Hold the result until taken; a new one may replace it on the take cycle.
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            is_draw <= (act == ACT_DRAW);
            case (act)
              ACT_DRAW: state <= S_RAW;
              ACT_JUMP: state <= S_JUMP;
              default:  state <= S_EMIT;
            endcase
          end
        end
        S_RAW:  state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM:  state <= S_EMIT;
        S_JUMP: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(JUMP_W - 1)) begin
            state <= S_JCOPY;
          end
        end
        S_JCOPY: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result loaded over an untaken transaction");

  a_cnt_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (state != S_JUMP) |-> (cnt == '0))
    else $error("jump counter not at zero outside a jump");

  a_jump_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load_jump |=> (in_stall && !cmd.emit))
    else $error("jump did not occupy the block");

  a_draw_no_early_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load_draw |=> (!cmd.emit ##1 !cmd.emit ##1 !cmd.emit))
    else $error("draw result emitted before pipeline finished");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the xoshiro256** generator: scoreboard, drivers, top.

import xs_pkg::*;

typedef struct {
  word_t               raw;
  logic [FRAC_W-1:0]   frac;
  logic [RANGE_W-1:0]  ranged;
} gen_result_t;

class xs_scoreboard;
  word_t              gen_words[4];
  logic [SEED_W-1:0]  seed_base;
  gen_result_t        expected_q[$];
  int                 n_errors;
  int                 n_results;
  int                 n_draws;
  int                 n_jumps;
  int                 n_reseeds;
  int                 n_unused;
  int                 n_seeds;

  function new();
    gen_words[0] = 64'd1;
    gen_words[1] = 64'd2;
    gen_words[2] = 64'd3;
    gen_words[3] = 64'd4;
    seed_base = SEED_W'(1);
    n_errors = 0;
    n_results = 0;
    n_draws = 0;
    n_jumps = 0;
    n_reseeds = 0;
    n_unused = 0;
    n_seeds = 0;
  endfunction

  static function word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // One generator step; returns the scrambled output of the old state.
  function word_t step_state();
    word_t scrambled;
    word_t t;
    scrambled = rotl(gen_words[1] * 64'd5, 7) * 64'd9;
    t = gen_words[1] << 17;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= t;
    gen_words[3] = rotl(gen_words[3], 45);
    return scrambled;
  endfunction

  function void jump_ahead();
    word_t poly[4];
    word_t acc[4];
    poly[0] = 64'h180ec6d33cfd0aba;
    poly[1] = 64'hd5a61266f0c9392c;
    poly[2] = 64'ha9582618e03fc9aa;
    poly[3] = 64'h39abdc4529b1661c;
    for (int k = 0; k < 4; k++) acc[k] = '0;
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 64; b++) begin
        if (poly[w][b]) begin
          for (int k = 0; k < 4; k++) acc[k] ^= gen_words[k];
        end
        void'(step_state());
      end
    end
    for (int k = 0; k < 4; k++) gen_words[k] = acc[k];
  endfunction

  function void set_seed(logic [SEED_W-1:0] v);
    seed_base = v;
    n_seeds++;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Note an accepted input transaction and queue the result it must produce.
  function void note_input(action_t act, logic [RANGE_W-1:0] rm);
    gen_result_t r;
    logic [FRAC_W+RANGE_W-1:0] prod;
    r.raw = '0;
    r.frac = '0;
    r.ranged = '0;
    case (act)
      ACT_DRAW: begin
        r.raw = step_state();
        r.frac = r.raw[WORD_W-1:WORD_W-FRAC_W];
        prod = r.frac * rm;
        r.ranged = prod[FRAC_W+RANGE_W-1:FRAC_W] + 1'b1;
        n_draws++;
      end
      ACT_JUMP: begin
        jump_ahead();
        n_jumps++;
      end
      ACT_RESEED: begin
        for (int k = 0; k < 4; k++) gen_words[k] = word_t'(seed_base) + word_t'(k);
        n_reseeds++;
      end
      default: n_unused++;
    endcase
    expected_q.push_back(r);
  endfunction

  function void check_result(word_t raw, logic [FRAC_W-1:0] frac,
                             logic [RANGE_W-1:0] ranged);
    gen_result_t exp_r;
    if (expected_q.size() == 0) begin
      $error("result transaction with nothing pending: raw_value %h", raw);
      n_errors++;
      return;
    end
    exp_r = expected_q.pop_front();
    n_results++;
    if (raw !== exp_r.raw) begin
      $error("raw_value: expected %h, got %h", exp_r.raw, raw);
      n_errors++;
    end
    if (frac !== exp_r.frac) begin
      $error("fraction: expected %h, got %h", exp_r.frac, frac);
      n_errors++;
    end
    if (ranged !== exp_r.ranged) begin
      $error("ranged_value: expected %h, got %h", exp_r.ranged, ranged);
      n_errors++;
    end
  endfunction
endclass

module tb_top;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          action;
  logic [RANGE_W-1:0]  range_max;
  logic                out_valid;
  logic                out_stall;
  word_t               raw_value;
  logic [FRAC_W-1:0]   fraction;
  logic [RANGE_W-1:0]  ranged_value;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SEED_W-1:0]   seed;

  xs_scoreboard sb = new();
  bit           idle_on = 1'b1;

  always #5 clk = ~clk;

  xoshiro256ss_generator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .range_max    (range_max),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raw_value    (raw_value),
    .fraction     (fraction),
    .ranged_value (ranged_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .seed         (seed)
  );

  // Called on a rising-edge time step; returns on the edge that accepts the item.
  task automatic send_item(action_t act, logic [RANGE_W-1:0] rm);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    range_max <= rm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(act, rm);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_seed(logic [SEED_W-1:0] v);
    wait_drained();
    // let the last transaction clear the datapath
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    seed      <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_seed(v);
  endtask

  // Result side: hold off for a random number of cycles after each transaction while idle_on is set.
  initial begin
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(raw_value, fraction, ranged_value);
        hold = idle_on ? $urandom_range(0, 11) : 0;
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0);
    end
  end

  initial begin
    action_t             act;
    logic [RANGE_W-1:0]  rm;
    int                  pick;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    action    <= ACT_DRAW;
    range_max <= '0;
    cfg_valid <= 1'b0;
    seed      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: range extremes, every action, unused code, seed extremes.
    send_item(ACT_DRAW, 32'd0);
    send_item(ACT_DRAW, 32'd1);
    send_item(ACT_DRAW, 32'hFFFF_FFFF);
    send_item(ACT_DRAW, 32'h8000_0000);
    send_item(ACT_NONE, 32'hFFFF_FFFF);
    send_item(ACT_DRAW, 32'd2);
    send_item(ACT_JUMP, 32'h5A5A_A5A5);
    send_item(ACT_DRAW, 32'd1000);
    send_item(ACT_RESEED, 32'd0);
    send_item(ACT_DRAW, 32'hFFFF_FFFF);
    write_seed(31'h7FFF_FFFF);
    send_item(ACT_RESEED, $urandom);
    send_item(ACT_DRAW, 32'hFFFF_FFFF);
    send_item(ACT_DRAW, 32'd0);
    send_item(ACT_JUMP, 32'd0);
    send_item(ACT_DRAW, 32'd7);
    write_seed(31'd0);
    send_item(ACT_RESEED, 32'hFFFF_FFFF);
    send_item(ACT_DRAW, 32'd1);
    send_item(ACT_DRAW, 32'hFFFF_FFFF);
    send_item(ACT_NONE, 32'd0);
    send_item(ACT_DRAW, 32'h0001_0000);

    // Random: eight phases, each with its own seed; every third phase runs flat out.
    for (int p = 0; p < 8; p++) begin
      if (p == 3) write_seed(31'd0);
      else if (p == 6) write_seed(31'h7FFF_FFFF);
      else write_seed(SEED_W'($urandom_range(0, 32'h7FFF_FFFF)));
      idle_on = (p % 3 != 1);
      for (int i = 0; i < 100; i++) begin
        if (i == 50 && p % 2 == 0) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 78) act = ACT_DRAW;
        else if (pick < 86) act = ACT_RESEED;
        else if (pick < 92) act = ACT_NONE;
        else act = ACT_JUMP;
        case ($urandom_range(0, 3))
          0: rm = $urandom_range(0, 16);
          1: rm = 32'hFFFF_FFFF - $urandom_range(0, 3);
          default: rm = $urandom;
        endcase
        send_item(act, rm);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Covered %0d draws, %0d jumps, %0d reseeds, %0d unused codes, %0d seed writes.",
             sb.n_draws, sb.n_jumps, sb.n_reseeds, sb.n_unused, sb.n_seeds);
    $display("%0d results compared, %0d mismatches.", sb.n_results, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
